// ===== hw/rtl/sut_pkg.sv =====
// Shared types and constants for the two-channel tick-driven UART engine.
package sut_pkg;

  // Number of lanes the design can hold
  localparam int CH_MAX = 2;

  // Operation codes
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_SEND = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // Configuration register indexes
  localparam logic REG_BIT_TICKS   = 1'b0;
  localparam logic REG_START_TICKS = 1'b1;

  // Register reset values
  localparam logic [3:0] BIT_TICKS_RST   = 4'd3;
  localparam logic [3:0] START_TICKS_RST = 4'd4;

  // Start plus eight data bits, then stop
  localparam logic [3:0] FRAME_STEPS = 4'd9;

  // Per-lane status after the current beat
  typedef struct packed {
    logic       tx_level;
    logic       tx_free;
    logic       rx_ready;
    logic       send_taken;
    logic [7:0] rd_byte;
  } lane_stat_t;

  // One result beat
  typedef struct packed {
    logic [1:0] tx_lines;
    logic [7:0] read_byte;
    logic       send_taken;
    logic [1:0] tx_free_flags;
    logic [1:0] rx_ready_flags;
  } result_t;

endpackage

// ===== hw/rtl/sut_if.sv =====
// Request and response channel interfaces.
interface sut_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic       channel;
  logic [7:0] send_byte;
  logic [1:0] rx_lines;

  modport source (output valid, op, channel, send_byte, rx_lines, input ready);
  modport sink (input valid, op, channel, send_byte, rx_lines, output ready);
endinterface

interface sut_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] tx_lines;
  logic [7:0] read_byte;
  logic       send_taken;
  logic [1:0] tx_free_flags;
  logic [1:0] rx_ready_flags;

  modport source (output valid, tx_lines, read_byte, send_taken, tx_free_flags,
                  rx_ready_flags, input ready);
  modport sink (input valid, tx_lines, read_byte, send_taken, tx_free_flags,
                rx_ready_flags, output ready);
endinterface

// ===== hw/rtl/sut_lane.sv =====
// One UART channel: receiver and transmitter state, advanced once per beat.
module sut_lane (
  input  logic               clk,
  input  logic               rst,
  input  logic               tick,
  input  logic               send_hit,
  input  logic               read_hit,
  input  logic               line,
  input  logic [7:0]         send_byte,
  input  logic [3:0]         bit_ticks,
  input  logic [3:0]         start_ticks,
  output sut_pkg::lane_stat_t stat
);
  import sut_pkg::*;

  logic       rx_active, rx_active_next;
  logic [3:0] rx_tick_count, rx_tick_count_next;
  logic [3:0] rx_bits_left, rx_bits_left_next;
  logic [7:0] rx_shift, rx_shift_next;
  logic [7:0] rx_hold, rx_hold_next;
  logic       rx_ready, rx_ready_next;
  logic       tx_active, tx_active_next;
  logic       tx_free, tx_free_next;
  logic [3:0] tx_tick_count, tx_tick_count_next;
  logic [3:0] tx_bits_left, tx_bits_left_next;
  logic [7:0] tx_shift, tx_shift_next;
  logic [7:0] tx_hold, tx_hold_next;
  logic       tx_level, tx_level_next;

  logic [3:0] rx_cnt_dec, rx_bits_dec, tx_cnt_dec, tx_bits_dec;

  assign rx_cnt_dec  = rx_tick_count - 4'd1;
  assign rx_bits_dec = rx_bits_left - 4'd1;
  assign tx_cnt_dec  = tx_tick_count - 4'd1;
  assign tx_bits_dec = tx_bits_left - 4'd1;

  // Receiver: hunt for start level, then sample at bit middles
  always_comb begin
    rx_active_next     = rx_active;
    rx_tick_count_next = rx_tick_count;
    rx_bits_left_next  = rx_bits_left;
    rx_shift_next      = rx_shift;
    rx_hold_next       = rx_hold;
    rx_ready_next      = rx_ready;
    if (tick) begin
      if (rx_active) begin
        if (rx_cnt_dec == 4'd0) begin
          rx_tick_count_next = bit_ticks;
          rx_bits_left_next  = rx_bits_dec;
          if (rx_bits_dec == 4'd0) begin
            rx_hold_next   = rx_shift;
            rx_active_next = 1'b0;
            rx_ready_next  = 1'b1;
          end else begin
            rx_shift_next = {line, rx_shift[7:1]};
          end
        end else begin
          rx_tick_count_next = rx_cnt_dec;
        end
      end else if (!line) begin
        rx_active_next     = 1'b1;
        rx_tick_count_next = start_ticks;
        rx_bits_left_next  = FRAME_STEPS;
      end
    end else if (read_hit) begin
      rx_ready_next = 1'b0;
    end
  end

  // Transmitter: free-running bit divider, frame shifter on each bit edge
  always_comb begin
    tx_active_next     = tx_active;
    tx_free_next       = tx_free;
    tx_tick_count_next = tx_tick_count;
    tx_bits_left_next  = tx_bits_left;
    tx_shift_next      = tx_shift;
    tx_hold_next       = tx_hold;
    tx_level_next      = tx_level;
    if (tick) begin
      if (tx_cnt_dec != 4'd0) begin
        tx_tick_count_next = tx_cnt_dec;
      end else begin
        tx_tick_count_next = bit_ticks;
        if (tx_active) begin
          if (tx_bits_left == 4'd0) begin
            tx_level_next     = 1'b0;
            tx_shift_next     = tx_hold;
            tx_bits_left_next = FRAME_STEPS;
          end else begin
            tx_bits_left_next = tx_bits_dec;
            if (tx_bits_dec == 4'd0) begin
              tx_level_next  = 1'b1;
              tx_active_next = 1'b0;
              tx_free_next   = 1'b1;
            end else begin
              tx_level_next = tx_shift[0];
              tx_shift_next = {1'b0, tx_shift[7:1]};
            end
          end
        end
      end
    end else if (send_hit && tx_free) begin
      tx_free_next   = 1'b0;
      tx_hold_next   = send_byte;
      tx_active_next = 1'b1;
    end
  end

  // Hold lane state
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_active     <= 1'b0;
      rx_tick_count <= 4'd0;
      rx_bits_left  <= 4'd0;
      rx_shift      <= 8'd0;
      rx_hold       <= 8'd0;
      rx_ready      <= 1'b1;
      tx_active     <= 1'b0;
      tx_free       <= 1'b1;
      tx_tick_count <= BIT_TICKS_RST;
      tx_bits_left  <= 4'd0;
      tx_shift      <= 8'd0;
      tx_hold       <= 8'd0;
      tx_level      <= 1'b1;
    end else begin
      rx_active     <= rx_active_next;
      rx_tick_count <= rx_tick_count_next;
      rx_bits_left  <= rx_bits_left_next;
      rx_shift      <= rx_shift_next;
      rx_hold       <= rx_hold_next;
      rx_ready      <= rx_ready_next;
      tx_active     <= tx_active_next;
      tx_free       <= tx_free_next;
      tx_tick_count <= tx_tick_count_next;
      tx_bits_left  <= tx_bits_left_next;
      tx_shift      <= tx_shift_next;
      tx_hold       <= tx_hold_next;
      tx_level      <= tx_level_next;
    end
  end

  // Report state as it stands after this beat
  assign stat.tx_level   = tx_level_next;
  assign stat.tx_free    = tx_free_next;
  assign stat.rx_ready   = rx_ready_next;
  assign stat.send_taken = send_hit & tx_free;
  assign stat.rd_byte    = read_hit ? rx_hold : 8'd0;

endmodule

// ===== hw/rtl/sut_merge.sv =====
// Combine lane status into one result beat and buffer it with a skid stage.
module sut_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  sut_pkg::lane_stat_t stat [sut_pkg::CH_MAX],
  output logic                in_ready,
  sut_rsp_if.source           rsp
);
  import sut_pkg::*;

  result_t merged;
  result_t out_data, skid_data;
  logic    out_valid, skid_valid;
  logic    out_open;

  // Pack flags and OR the addressed lane's read and send results
  always_comb begin
    merged = '0;
    for (int c = 0; c < CH_MAX; c++) begin
      merged.tx_lines[c]       = stat[c].tx_level;
      merged.tx_free_flags[c]  = stat[c].tx_free;
      merged.rx_ready_flags[c] = stat[c].rx_ready;
      merged.send_taken        = merged.send_taken | stat[c].send_taken;
      merged.read_byte         = merged.read_byte | stat[c].rd_byte;
    end
  end

  assign out_open = !out_valid || rsp.ready;
  assign in_ready = !skid_valid;

  // Advance output register; park a beat in the skid stage on stall
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_open) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_open) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= merged;
      end
    end else if (accept) begin
      skid_data <= merged;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.tx_lines       = out_data.tx_lines;
  assign rsp.read_byte      = out_data.read_byte;
  assign rsp.send_taken     = out_data.send_taken;
  assign rsp.tx_free_flags  = out_data.tx_free_flags;
  assign rsp.rx_ready_flags = out_data.rx_ready_flags;

endmodule

// ===== hw/rtl/soft_uart_tick_engine.sv =====
// Top level of the two-channel tick-driven 8N1 UART engine.
//
// Usage: each request beat on req carries one operation. A tick samples
// rx_lines and advances every channel's receiver and transmitter by one
// oversample tick; a send offers send_byte to one channel's transmitter;
// a read returns that channel's held byte and clears its ready flag.
// Every request produces exactly one response beat on rsp with the line
// levels and flags as they stand after the operation.
// The response is registered in the output register, or in the skid stage
// when rsp stalls. One request per cycle is sustained while rsp takes beats;
// the per-channel lanes report their status combinationally and a two-entry
// output buffer (output register plus skid stage) keeps req ready while one response waits.
// When rsp stalls, the second waiting response fills the skid stage and
// req drops ready until rsp takes a beat.
// Reset (rst, synchronous) returns all channels to idle: lines high,
// transmitters free, ready flags set, bit_ticks 3, start_ticks 4.
// Write bit_ticks and start_ticks through cfg_we, cfg_index and cfg_data
// only while no response is outstanding.
module soft_uart_tick_engine #(
  parameter int CHANNELS = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [3:0] cfg_data,
  sut_req_if.sink    req,
  sut_rsp_if.source  rsp
);
  import sut_pkg::*;

  logic [3:0] bit_ticks_reg;
  logic [3:0] start_ticks_reg;
  logic       accept;
  logic       tick;
  lane_stat_t stat [CH_MAX];

  assign accept = req.valid && req.ready;
  assign tick   = accept && (req.op == OP_TICK);

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_ticks_reg   <= BIT_TICKS_RST;
      start_ticks_reg <= START_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BIT_TICKS:   bit_ticks_reg   <= cfg_data;
        REG_START_TICKS: start_ticks_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  // One lane per present channel; absent lanes report zero
  for (genvar c = 0; c < CH_MAX; c++) begin : g_lane
    if (c < CHANNELS) begin : g_on
      sut_lane u_lane (
        .clk        (clk),
        .rst        (rst),
        .tick       (tick),
        .send_hit   (accept && (req.op == OP_SEND) && (req.channel == 1'(c))),
        .read_hit   (accept && (req.op == OP_READ) && (req.channel == 1'(c))),
        .line       (req.rx_lines[c]),
        .send_byte  (req.send_byte),
        .bit_ticks  (bit_ticks_reg),
        .start_ticks(start_ticks_reg),
        .stat       (stat[c])
      );
    end else begin : g_off
      assign stat[c] = '0;
    end
  end

  sut_merge u_merge (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .stat    (stat),
    .in_ready(req.ready),
    .rsp     (rsp)
  );

  // A send result and a read result never share one beat
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.send_taken && (rsp.read_byte != 8'd0)))
    else $error("send_taken and read_byte both set");

  // Request side only backs off while a response is held
  assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> rsp.valid)
    else $error("req not ready with empty response side");

  // Skid fills only after a stalled response
  assert property (@(posedge clk) disable iff (rst)
    $fell(req.ready) |-> $past(rsp.valid && !rsp.ready))
    else $error("skid filled without a stall");

endmodule

// ===== verif/soft_uart_tick_engine_test.sv =====
// Self-checking testbench for the two-channel tick-driven 8N1 UART engine.
module soft_uart_tick_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sut_pkg::*;

  localparam int NCH = 2;
  // Unused operation code, must leave the state alone
  localparam logic [1:0] OP_NONE = 2'd3;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic       cfg_index;
  logic [3:0] cfg_data;

  sut_req_if req_ch();
  sut_rsp_if rsp_ch();

  soft_uart_tick_engine #(.CHANNELS(NCH)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Behavioral copy of the engine: registers and per-channel state
  logic [3:0] m_bit_ticks;
  logic [3:0] m_start_ticks;
  logic       rx_busy [NCH];
  logic [3:0] rx_cnt [NCH];
  logic [3:0] rx_left [NCH];
  logic [7:0] rx_sr [NCH];
  logic [7:0] rx_buf [NCH];
  logic       rx_full [NCH];
  logic       tx_busy [NCH];
  logic       tx_open [NCH];
  logic [3:0] tx_cnt [NCH];
  logic [3:0] tx_left [NCH];
  logic [7:0] tx_sr [NCH];
  logic [7:0] tx_buf [NCH];
  logic       tx_pin [NCH];

  result_t status_due [$];
  logic    rx_wave [NCH][$];
  int      fail_count = 0;
  int      send_idle_pct = 0;
  int      stall_pct = 0;

  function automatic void model_reset();
    m_bit_ticks   = BIT_TICKS_RST;
    m_start_ticks = START_TICKS_RST;
    for (int c = 0; c < NCH; c++) begin
      rx_busy[c] = 1'b0;
      rx_cnt[c]  = '0;
      rx_left[c] = '0;
      rx_sr[c]   = '0;
      rx_buf[c]  = '0;
      rx_full[c] = 1'b1;
      tx_busy[c] = 1'b0;
      tx_open[c] = 1'b1;
      tx_cnt[c]  = BIT_TICKS_RST;
      tx_left[c] = '0;
      tx_sr[c]   = '0;
      tx_buf[c]  = '0;
      tx_pin[c]  = 1'b1;
    end
  endfunction

  // Receiver: hunt for a low level, then sample each bit middle
  function automatic void rx_advance(int c, logic line);
    if (rx_busy[c]) begin
      rx_cnt[c] = rx_cnt[c] - 4'd1;
      if (rx_cnt[c] == 4'd0) begin
        rx_cnt[c]  = m_bit_ticks;
        rx_left[c] = rx_left[c] - 4'd1;
        if (rx_left[c] == 4'd0) begin
          rx_buf[c]  = rx_sr[c];
          rx_busy[c] = 1'b0;
          rx_full[c] = 1'b1;
        end else begin
          rx_sr[c] = {line, rx_sr[c][7:1]};
        end
      end
    end else if (!line) begin
      rx_busy[c] = 1'b1;
      rx_cnt[c]  = m_start_ticks;
      rx_left[c] = FRAME_STEPS;
    end
  endfunction

  // Transmitter: free-running divider, start bit, eight data bits, stop
  function automatic void tx_advance(int c);
    tx_cnt[c] = tx_cnt[c] - 4'd1;
    if (tx_cnt[c] != 4'd0) return;
    tx_cnt[c] = m_bit_ticks;
    if (!tx_busy[c]) return;
    if (tx_left[c] == 4'd0) begin
      tx_pin[c]  = 1'b0;
      tx_sr[c]   = tx_buf[c];
      tx_left[c] = FRAME_STEPS;
    end else begin
      tx_left[c] = tx_left[c] - 4'd1;
      if (tx_left[c] == 4'd0) begin
        tx_pin[c]  = 1'b1;
        tx_busy[c] = 1'b0;
        tx_open[c] = 1'b1;
      end else begin
        tx_pin[c] = tx_sr[c][0];
        tx_sr[c]  = tx_sr[c] >> 1;
      end
    end
  endfunction

  // Apply one operation and return the status the engine must report
  function automatic result_t uart_predict(logic [1:0] op, logic ch, logic [7:0] data,
                                           logic [1:0] lines);
    result_t r;
    r = '0;
    case (op)
      OP_TICK: begin
        for (int c = 0; c < NCH; c++) begin
          rx_advance(c, lines[c]);
          tx_advance(c);
        end
      end
      OP_SEND: begin
        if (int'(ch) < NCH && tx_open[ch]) begin
          tx_open[ch] = 1'b0;
          tx_buf[ch]  = data;
          tx_busy[ch] = 1'b1;
          r.send_taken = 1'b1;
        end
      end
      OP_READ: begin
        if (int'(ch) < NCH) begin
          r.read_byte = rx_buf[ch];
          rx_full[ch] = 1'b0;
        end
      end
      default: ;
    endcase
    for (int c = 0; c < NCH; c++) begin
      r.tx_lines[c]       = tx_pin[c];
      r.tx_free_flags[c]  = tx_open[c];
      r.rx_ready_flags[c] = rx_full[c];
    end
    return r;
  endfunction

  // Offer one beat after a random gap, record its status on acceptance
  task automatic put_item(logic [1:0] op, logic ch, logic [7:0] data, logic [1:0] lines);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.op        <= op;
    req_ch.channel   <= ch;
    req_ch.send_byte <= data;
    req_ch.rx_lines  <= lines;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    status_due.push_back(uart_predict(op, ch, data, lines));
  endtask

  // Drop valid and wait until every status beat is back
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write both registers while the engine is idle
  task automatic write_regs(logic [3:0] bit_ticks, logic [3:0] start_ticks);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_BIT_TICKS;
    cfg_data  <= bit_ticks;
    @(posedge clk);
    cfg_index <= REG_START_TICKS;
    cfg_data  <= start_ticks;
    @(posedge clk);
    cfg_we        <= 1'b0;
    m_bit_ticks   = bit_ticks;
    m_start_ticks = start_ticks;
  endtask

  // Queue one 8N1 frame on a receive line, sometimes with corrupted levels
  task automatic load_frame(int c);
    int         period;
    int         idx;
    logic [7:0] data;
    period = (m_bit_ticks == 4'd0) ? 16 : int'(m_bit_ticks);
    data   = 8'($urandom);
    repeat (period) rx_wave[c].push_back(1'b0);
    for (int i = 0; i < 8; i++)
      repeat (period) rx_wave[c].push_back(data[i]);
    repeat (period + $urandom_range(0, period)) rx_wave[c].push_back(1'b1);
    if ($urandom_range(9) == 0) begin
      repeat (2) begin
        idx = $urandom_range(rx_wave[c].size() - 1);
        rx_wave[c][idx] = ~rx_wave[c][idx];
      end
    end
  endtask

  // Reads right after reset return zero and clear the ready flags
  task automatic test_reset_state();
    put_item(OP_READ, 1'b0, 8'h00, 2'b11);
    put_item(OP_READ, 1'b1, 8'hFF, 2'b11);
    put_item(OP_NONE, 1'b1, 8'hFF, 2'b00);
    put_item(OP_TICK, 1'b0, 8'h00, 2'b11);
  endtask

  // Busy sends, unused op codes, start levels on every line pattern
  task automatic test_directed_ops();
    put_item(OP_SEND, 1'b0, 8'hFF, 2'b11);
    put_item(OP_SEND, 1'b0, 8'h00, 2'b11);
    put_item(OP_SEND, 1'b1, 8'h00, 2'b00);
    put_item(OP_SEND, 1'b1, 8'hA5, 2'b11);
    put_item(OP_NONE, 1'b0, 8'h5A, 2'b01);
    put_item(OP_TICK, 1'b1, 8'hFF, 2'b01);
    put_item(OP_TICK, 1'b0, 8'h00, 2'b10);
    put_item(OP_TICK, 1'b0, 8'h00, 2'b00);
    put_item(OP_TICK, 1'b0, 8'h00, 2'b11);
    put_item(OP_READ, 1'b0, 8'h00, 2'b11);
    repeat (8) put_item(OP_TICK, 1'b0, 8'h00, 2'b00);
    put_item(OP_READ, 1'b1, 8'h00, 2'b11);
    put_item(OP_SEND, 1'b0, 8'h3C, 2'b11);
  endtask

  // Random traffic: mostly ticks carrying whole frames, plus sends and reads
  task automatic test_line_traffic(int items, int idle, int stall, logic [3:0] bit_ticks,
                                   logic [3:0] start_ticks);
    int         pick;
    logic [1:0] op;
    logic       ch;
    logic [7:0] data;
    logic [1:0] lines;
    write_regs(bit_ticks, start_ticks);
    send_idle_pct = idle;
    stall_pct     = stall;
    for (int c = 0; c < NCH; c++) rx_wave[c].delete();
    repeat (items) begin
      pick  = $urandom_range(99);
      ch    = 1'($urandom);
      data  = 8'($urandom);
      lines = 2'($urandom);
      if (pick < 62) begin
        op = OP_TICK;
        if (pick < 58) begin
          for (int c = 0; c < NCH; c++) begin
            if (rx_wave[c].size() == 0 && $urandom_range(5) == 0) load_frame(c);
            lines[c] = (rx_wave[c].size() != 0) ? rx_wave[c].pop_front() : 1'b1;
          end
        end
      end else if (pick < 78) begin
        op = OP_SEND;
      end else if (pick < 94) begin
        op = OP_READ;
        if (rx_full[0] != rx_full[1]) ch = rx_full[1];
      end else begin
        op = OP_NONE;
      end
      put_item(op, ch, data, lines);
    end
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Compare every accepted status beat with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (status_due.size() == 0) begin
        $error("status beat with no request outstanding");
        fail_count++;
      end else begin
        want = status_due.pop_front();
        check_field("tx_lines", {6'd0, want.tx_lines}, {6'd0, rsp_ch.tx_lines});
        check_field("read_byte", want.read_byte, rsp_ch.read_byte);
        check_field("send_taken", {7'd0, want.send_taken}, {7'd0, rsp_ch.send_taken});
        check_field("tx_free_flags", {6'd0, want.tx_free_flags},
                    {6'd0, rsp_ch.tx_free_flags});
        check_field("rx_ready_flags", {6'd0, want.rx_ready_flags},
                    {6'd0, rsp_ch.rx_ready_flags});
      end
    end
  end

  // Stall the status channel at random
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_BIT_TICKS;
    cfg_data         <= '0;
    req_ch.valid     <= 1'b0;
    req_ch.op        <= OP_TICK;
    req_ch.channel   <= 1'b0;
    req_ch.send_byte <= '0;
    req_ch.rx_lines  <= 2'b11;
    model_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_directed_ops();
    test_line_traffic(300, 0, 0, BIT_TICKS_RST, START_TICKS_RST);
    test_line_traffic(250, 69, 0, 4'd1, 4'd1);
    test_line_traffic(250, 0, 69, 4'd2, 4'd3);
    test_line_traffic(250, 13, 13, 4'd0, 4'd0);
    test_line_traffic(300, 0, 0, 4'd15, 4'd15);
    test_line_traffic(250, 13, 13, 4'($urandom_range(1, 15)), 4'($urandom_range(1, 15)));

    settle();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Give up on a hung handshake
  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
